// ===== hw/rtl/qat_pkg.sv =====
// ----------------------------------------------------------------------------
// qat_pkg - quoted argument tokenizer package
// shared types, character codes and register defaults for the tokenizer
// ----------------------------------------------------------------------------
package qat_pkg;

  // default sizes
  localparam int unsigned MaxArgBytesDef  = 2048;
  localparam int unsigned EofWordBytesDef = 8;

  // configuration register reset values
  localparam logic [63:0] EofWordRst    = 64'd95;
  localparam logic [3:0]  EofWordLenRst = 4'd1;
  localparam logic [11:0] ArgLimitRst   = 12'd2048;

  // configuration register widths
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 2;

  // character codes
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChNl    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChBs    = 8'h5c;

  typedef enum logic [CfgIdxW-1:0] {
    CfgZeroMode = 2'd0,
    CfgEofWord  = 2'd1,
    CfgEofLen   = 2'd2,
    CfgArgLimit = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    QuoteNone   = 2'd0,
    QuoteSingle = 2'd1,
    QuoteDouble = 2'd2
  } quote_e;

  typedef enum logic [1:0] {
    ErrNone   = 2'd0,
    ErrEscape = 2'd1,
    ErrQuote  = 2'd2,
    ErrLength = 2'd3
  } err_e;

  // parser state apart from the stored length
  typedef struct packed {
    quote_e quote;
    logic   esc_pending;
    logic   eof_match;
    logic   halted;
  } pstate_t;

  // one result transaction
  typedef struct packed {
    logic       store_valid;
    logic [7:0] store_byte;
    logic       arg_done;
    logic       line_done;
    logic       stop;
    err_e       error_code;
  } result_t;

endpackage

// ===== hw/rtl/quoted_argument_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_core - shell-style quoted word splitter
// splits a byte stream into arguments with quotes, escapes and eof word
// ----------------------------------------------------------------------------
// The core takes one byte (or an end-of-input mark) per input transaction and
// returns exactly one result transaction for it. It sustains one transaction
// per clock while the output is not stalled; the input register loads at the
// accepting edge and the result register loads from it when free, so the
// result shows on the output from the result register. The rate is set by the
// per-byte step: quote/escape state, the stored length and the eof-word
// compare are updated combinationally from the input register into the
// result register. The result register holds a finished result while the
// input register can still take the next transaction; a stall on the output
// reaches in_stall_o combinationally once both registers are full. The user
// must write configuration through cfg_we_i / cfg_idx_i / cfg_wdata_i only
// while the core is idle; the core does not enforce this. After a stop or
// any error the core keeps answering with all-zero results until reset.
module quoted_argument_tokenizer_core #(
  parameter int unsigned MAX_ARG_BYTES  = qat_pkg::MaxArgBytesDef,
  parameter int unsigned EOF_WORD_BYTES = qat_pkg::EofWordBytesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [qat_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [qat_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      in_byte_i,
  input  logic                            end_of_input_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            store_valid_o,
  output logic [7:0]                      store_byte_o,
  output logic                            arg_done_o,
  output logic                            line_done_o,
  output logic                            stop_o,
  output logic [1:0]                      error_code_o
);
  import qat_pkg::*;

  localparam int unsigned LenW  = $clog2(MAX_ARG_BYTES + 1);
  localparam int unsigned WordW = EOF_WORD_BYTES * 8;

  // configuration registers
  logic             zero_mode_q;
  logic [WordW-1:0] eof_word_q;
  logic [3:0]       eof_len_q;
  logic [11:0]      arg_limit_q;

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_eoi_q;

  // parser state
  pstate_t         state_q, state_d;
  logic [LenW-1:0] len_q, len_d;

  // result register
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  logic in_accept;
  logic out_free;
  logic s1_adv;

  // ---------------------------------------------------------------------------
  // configuration write port, no read-back
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_mode_q <= 1'b0;
      eof_word_q  <= WordW'(EofWordRst);
      eof_len_q   <= EofWordLenRst;
      arg_limit_q <= ArgLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgZeroMode: zero_mode_q <= cfg_wdata_i[0];
        CfgEofWord:  eof_word_q  <= cfg_wdata_i[WordW-1:0];
        CfgEofLen:   eof_len_q   <= cfg_wdata_i[3:0];
        CfgArgLimit: arg_limit_q <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: result register frees up when empty or being taken, the input
  // register moves into it whenever it is free
  // ---------------------------------------------------------------------------
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // per-byte step: quote / escape tracking, length check, eof word compare
  // ---------------------------------------------------------------------------
  pstate_t         step_state;
  logic [LenW-1:0] step_len;

  qat_step #(
    .MAX_ARG_BYTES  (MAX_ARG_BYTES),
    .EOF_WORD_BYTES (EOF_WORD_BYTES)
  ) u_step (
    .byte_i      (s1_byte_q),
    .eoi_i       (s1_eoi_q),
    .zero_mode_i (zero_mode_q),
    .eof_word_i  (eof_word_q),
    .eof_len_i   (eof_len_q),
    .arg_limit_i (arg_limit_q),
    .state_i     (state_q),
    .len_i       (len_q),
    .state_o     (step_state),
    .len_o       (step_len),
    .result_o    (res_d)
  );

  // state only moves when the transaction in the input register is consumed
  assign state_d = s1_adv ? step_state : state_q;
  assign len_d   = s1_adv ? step_len   : len_q;

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{quote: QuoteNone, esc_pending: 1'b0, eof_match: 1'b1,
                       halted: 1'b0};
      len_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
      len_q       <= len_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= in_byte_i;
      s1_eoi_q  <= end_of_input_i;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  // result ports
  assign out_valid_o   = out_valid_q;
  assign store_valid_o = res_q.store_valid;
  assign store_byte_o  = res_q.store_byte;
  assign arg_done_o    = res_q.arg_done;
  assign line_done_o   = res_q.line_done;
  assign stop_o        = res_q.stop;
  assign error_code_o  = res_q.error_code;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // once halted the core stays halted until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.halted |=> state_q.halted)
    else $error("halted state cleared without reset");

  // a stop or error result halts the parser
  a_halt_on_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (res_d.stop || res_d.error_code != ErrNone)) |=> state_q.halted)
    else $error("stop or error did not halt the parser");

  // stored length never passes the buffer size
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LenW'(MAX_ARG_BYTES) >= len_q)
    else $error("stored length beyond the argument buffer");

  // an empty input register never stalls the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty input register");

  // a stored byte never travels with an error or an argument end
  a_store_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && res_d.store_valid) |=>
      (res_q.error_code == ErrNone && !res_q.arg_done && !res_q.stop))
    else $error("stored byte mixed with an error or argument end");

endmodule

// ===== hw/rtl/qat_step.sv =====
// ----------------------------------------------------------------------------
// qat_step - tokenizer step logic
// next state and result for one byte or end-of-input mark
// ----------------------------------------------------------------------------
module qat_step #(
  parameter int unsigned MAX_ARG_BYTES  = qat_pkg::MaxArgBytesDef,
  parameter int unsigned EOF_WORD_BYTES = qat_pkg::EofWordBytesDef
) (
  input  logic [7:0]                         byte_i,
  input  logic                               eoi_i,
  input  logic                               zero_mode_i,
  input  logic [EOF_WORD_BYTES*8-1:0]        eof_word_i,
  input  logic [3:0]                         eof_len_i,
  input  logic [11:0]                        arg_limit_i,
  input  qat_pkg::pstate_t                   state_i,
  input  logic [$clog2(MAX_ARG_BYTES+1)-1:0] len_i,
  output qat_pkg::pstate_t                   state_o,
  output logic [$clog2(MAX_ARG_BYTES+1)-1:0] len_o,
  output qat_pkg::result_t                   result_o
);
  import qat_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_ARG_BYTES + 1);
  localparam int unsigned CmpW = (LenW > 12) ? LenW : 12;

  logic [CmpW-1:0] lim_eff;
  logic [3:0]      n_used;
  logic            line_end_c;
  logic            is_blank;
  logic            byte_hit;
  logic            complete;

  always_comb begin
    lim_eff = (CmpW'(arg_limit_i) > CmpW'(MAX_ARG_BYTES)) ? CmpW'(MAX_ARG_BYTES)
                                                           : CmpW'(arg_limit_i);
    n_used = (eof_len_i > 4'(EOF_WORD_BYTES)) ? 4'(EOF_WORD_BYTES) : eof_len_i;
    line_end_c = eoi_i || (byte_i == ChNul) || (byte_i == ChNl && !zero_mode_i);
    is_blank = (byte_i == ChSpace) || (byte_i == ChTab);

    // eof word byte at the current stored position
    byte_hit = 1'b0;
    for (int i = 0; i < int'(EOF_WORD_BYTES); i++) begin
      if (len_i == LenW'(i) && eof_word_i[i*8 +: 8] == byte_i) begin
        byte_hit = 1'b1;
      end
    end
  end

  always_comb begin
    state_o  = state_i;
    len_o    = len_i;
    result_o = '0;
    complete = 1'b0;

    if (state_i.halted) begin
      // everything ignored
    end else if (!eoi_i && CmpW'(len_i) >= lim_eff) begin
      state_o.halted      = 1'b1;
      result_o.error_code = ErrLength;
    end else if (line_end_c) begin
      if (state_i.esc_pending) begin
        state_o.halted      = 1'b1;
        result_o.error_code = ErrEscape;
      end else if (state_i.quote != QuoteNone) begin
        state_o.halted      = 1'b1;
        result_o.error_code = ErrQuote;
      end else begin
        complete           = 1'b1;
        result_o.line_done = 1'b1;
      end
    end else if (byte_i == ChDq && !zero_mode_i && !state_i.esc_pending &&
                 state_i.quote != QuoteSingle) begin
      state_o.quote = (state_i.quote == QuoteDouble) ? QuoteNone : QuoteDouble;
    end else if (byte_i == ChSq && !zero_mode_i && !state_i.esc_pending &&
                 state_i.quote != QuoteDouble) begin
      state_o.quote = (state_i.quote == QuoteSingle) ? QuoteNone : QuoteSingle;
    end else if (byte_i == ChBs && !zero_mode_i && state_i.quote == QuoteNone &&
                 !state_i.esc_pending) begin
      state_o.esc_pending = 1'b1;
    end else if (zero_mode_i || state_i.quote != QuoteNone || state_i.esc_pending ||
                 !is_blank) begin
      state_o.esc_pending = 1'b0;
      if (!(len_i < LenW'(n_used) && byte_hit)) begin
        state_o.eof_match = 1'b0;
      end
      len_o                = len_i + LenW'(1);
      result_o.store_valid = 1'b1;
      result_o.store_byte  = byte_i;
    end else begin
      complete = 1'b1;
    end

    if (complete) begin
      if (n_used != 4'd0 && state_i.eof_match && len_i == LenW'(n_used)) begin
        result_o.stop  = 1'b1;
        state_o.halted = 1'b1;
      end else begin
        result_o.arg_done = (len_i != '0);
        if (eoi_i) begin
          result_o.stop  = 1'b1;
          state_o.halted = 1'b1;
        end
      end
      len_o             = '0;
      state_o.eof_match = 1'b1;
    end
  end

endmodule
